@@ rtl/core/cpd_pkg.sv @@
package cpd_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int BYTE_W      = 8;
  localparam int TOTAL_W     = 24;
  localparam int SYM_W       = 3;
  localparam int PEND_W      = 2;
  localparam int LEFT_W      = $clog2(BYTE_W + 1);
  localparam int CMP_W       = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
  localparam int E_LEN       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SYM_W-1:0]  SYM_C = 3'd0;
  localparam logic [SYM_W-1:0]  SYM_R = 3'd1;
  localparam logic [SYM_W-1:0]  SYM_L = 3'd2;
  localparam logic [SYM_W-1:0]  SYM_S = 3'd3;
  localparam logic [SYM_W-1:0]  SYM_E = 3'd4;
  localparam logic [PEND_W-1:0] PEND_MAX = 2'd3;

  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [TOTAL_W-1:0]     total_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_byte;
    logic             finished;
  } result_t;

  typedef struct packed {
    logic stopped;
    logic push;
    logic pop;
  } eng_stat_t;

endpackage

@@ rtl/core/clers_prefix_code_decoder.sv @@
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------------
// bytes    | in        | push / full        | code_byte_i
// symbols  | out       | pop / empty        | symbol_o, last_of_byte_o, finished_o
// total    | in        | symbol_total_we_i  | symbol_total_i
//
// one code bit is decoded per cycle by the bit engine, unless it holds as told below;
// the rest of a byte is skipped once the symbol total has been reached
// a two-entry byte queue in front lets a new byte be pushed while the engine works
// a two-entry result queue behind lets the engine run while a result waits;
// the engine holds on a bit that ends a code word while that queue is full
// reset clears the total, the symbol count, the pending ones and both queues
module clers_prefix_code_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  logic [cpd_pkg::BYTE_W-1:0]      code_byte_i,
  output logic                            full,
  input  logic                            symbol_total_we_i,
  input  logic [cpd_pkg::TOTAL_W-1:0]     symbol_total_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [cpd_pkg::SYM_W-1:0]       symbol_o,
  output logic                            last_of_byte_o,
  output logic                            finished_o
);
  import cpd_pkg::*;

  logic      byte_empty, byte_pop, res_push, res_full;
  byte_t     byte_data;
  result_t   res_in, res_out;
  eng_stat_t stat;

  cpd_byte_queue u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (code_byte_i),
    .full_o  (full),
    .pop_i   (byte_pop),
    .empty_o (byte_empty),
    .data_o  (byte_data)
  );

  cpd_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (!byte_empty),
    .byte_i       (byte_data),
    .byte_pop_o   (byte_pop),
    .total_we_i   (symbol_total_we_i),
    .total_i      (symbol_total_i),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full),
    .stat_o       (stat)
  );

  cpd_result_queue u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign symbol_o       = res_out.symbol;
  assign last_of_byte_o = res_out.last_of_byte;
  assign finished_o     = res_out.finished;

`ifndef ASSERT_OFF
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.push |-> !res_full)
    else $error("result written into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop |-> !byte_empty)
    else $error("byte taken from an empty queue");

  a_silent_when_stopped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.stopped |-> !stat.push)
    else $error("symbol produced after the total was reached");

  a_finished_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.push && res_in.finished) |-> res_in.last_of_byte)
    else $error("finishing symbol not marked last of its byte");

  a_stop_after_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.push && res_in.finished && !symbol_total_we_i) |=> stat.stopped)
    else $error("decoding went on after the finishing symbol");
`endif

endmodule

@@ rtl/core/cpd_byte_queue.sv @@
module cpd_byte_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cpd_pkg::byte_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cpd_pkg::byte_t data_o
);
  import cpd_pkg::*;

  byte_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/cpd_result_queue.sv @@
module cpd_result_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cpd_pkg::result_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output cpd_pkg::result_t data_o
);
  import cpd_pkg::*;

  result_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/cpd_engine.sv @@
module cpd_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  cpd_pkg::byte_t     byte_i,
  output logic               byte_pop_o,
  input  logic               total_we_i,
  input  cpd_pkg::total_t    total_i,
  output logic               res_push_o,
  output cpd_pkg::result_t   res_o,
  input  logic               res_full_i,
  output cpd_pkg::eng_stat_t stat_o
);
  import cpd_pkg::*;

  total_t            total_q;
  count_t            done_q, done_d, done_inc;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic              busy_q, busy_d;
  byte_t             shift_q, shift_d;
  logic [LEFT_W-1:0] left_q, left_d;

  logic cur_bit, emit, stop, advance, finish, load, fin, more;

  assign cur_bit  = shift_q[BYTE_W-1];
  assign stop     = CMP_W'(done_q) >= CMP_W'(total_q);
  assign emit     = !cur_bit || (pend_q == PEND_MAX);
  // counter saturates at all ones
  assign done_inc = (&done_q) ? done_q : done_q + COUNT_WIDTH'(1);
  assign fin      = (CMP_W'(done_inc) == CMP_W'(total_q));
  // low bits are refilled with ones, so a zero there is a real code end;
  // otherwise only a full run of ones can still complete an E
  assign more     = !(&shift_q[BYTE_W-2:0]) || (left_q > LEFT_W'(E_LEN));

  assign advance    = busy_q && !stop && (!emit || !res_full_i);
  assign res_push_o = busy_q && !stop && emit && !res_full_i;
  assign finish     = busy_q && (stop || (advance && left_q == LEFT_W'(1)));
  assign load       = byte_valid_i && (!busy_q || finish);
  assign byte_pop_o = load;

  assign res_o.symbol       = cur_bit ? SYM_E : {1'b0, pend_q};
  assign res_o.finished     = fin;
  assign res_o.last_of_byte = fin || !more;

  assign stat_o.stopped = stop;
  assign stat_o.push    = res_push_o;
  assign stat_o.pop     = load;

  always_comb begin
    done_d  = done_q;
    pend_d  = pend_q;
    shift_d = shift_q;
    left_d  = left_q;
    busy_d  = busy_q;
    if (advance) begin
      shift_d = {shift_q[BYTE_W-2:0], 1'b1};
      left_d  = left_q - LEFT_W'(1);
      if (emit) begin
        pend_d = '0;
        done_d = done_inc;
      end else begin
        pend_d = pend_q + PEND_W'(1);
      end
    end
    if (finish) begin
      busy_d = 1'b0;
    end
    if (load) begin
      busy_d  = 1'b1;
      shift_d = byte_i;
      left_d  = LEFT_W'(BYTE_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      done_q  <= '0;
      pend_q  <= '0;
      busy_q  <= 1'b0;
      left_q  <= '0;
    end else begin
      if (total_we_i) begin
        total_q <= total_i;
      end
      done_q <= done_d;
      pend_q <= pend_d;
      busy_q <= busy_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

endmodule

@@ tb/clers_prefix_code_decoder_checker.sv @@
`timescale 1ns / 100ps

module clers_prefix_code_decoder_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       full_i,
  input  cpd_pkg::byte_t             code_byte_i,
  input  logic                       total_we_i,
  input  cpd_pkg::total_t            total_i,
  input  logic                       empty_i,
  input  logic                       pop_i,
  input  logic [cpd_pkg::SYM_W-1:0]  symbol_i,
  input  logic                       last_of_byte_i,
  input  logic                       finished_i,
  output int                         mismatches_o,
  output int                         symbols_checked_o,
  output int                         pending_o,
  output logic                       live_o,
  output cpd_pkg::count_t            emitted_o
);
  import cpd_pkg::*;

  // own copy of the decoder state
  logic [PEND_W-1:0] open_ones;
  count_t            emitted;
  total_t            sym_total;
  result_t           symbol_q[$];
  int                mismatch_cnt;
  int                checked_cnt;

  assign mismatches_o      = mismatch_cnt;
  assign symbols_checked_o = checked_cnt;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("[%0t] symbol check: %s got %0d, expected %0d", $time, what, got_v, want_v);
    mismatch_cnt++;
  endtask

  // walks the byte msb first and queues the symbols that complete inside it
  function automatic void decode_byte(input byte_t b);
    result_t          held;
    logic             have;
    logic [SYM_W-1:0] sym;
    logic             emit;
    have = 1'b0;
    held = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (emitted >= sym_total) break;
      emit = 1'b0;
      sym  = SYM_C;
      if (!b[i]) begin
        emit = 1'b1;
        case (open_ones)
          2'd0:    sym = SYM_C;
          2'd1:    sym = SYM_R;
          2'd2:    sym = SYM_L;
          default: sym = SYM_S;
        endcase
      end else if (open_ones == PEND_MAX) begin
        emit = 1'b1;
        sym  = SYM_E;
      end else begin
        open_ones = open_ones + 1'b1;
      end
      if (emit) begin
        open_ones = '0;
        if (emitted != '1) emitted = emitted + 1'b1;
        if (have) symbol_q = {symbol_q, held};
        held.symbol       = sym;
        held.last_of_byte = 1'b0;
        held.finished     = (emitted == sym_total);
        have = 1'b1;
      end
    end
    if (have) begin
      held.last_of_byte = 1'b1;
      symbol_q = {symbol_q, held};
    end
  endfunction

  task automatic check_symbol();
    result_t want;
    if (symbol_q.size() == 0) begin
      report_mismatch("symbol with nothing outstanding", symbol_i, -1);
    end else begin
      want = symbol_q.pop_front();
      checked_cnt++;
      if (symbol_i !== want.symbol)
        report_mismatch("symbol", symbol_i, want.symbol);
      if (last_of_byte_i !== want.last_of_byte)
        report_mismatch("last_of_byte", last_of_byte_i, want.last_of_byte);
      if (finished_i !== want.finished)
        report_mismatch("finished", finished_i, want.finished);
    end
  endtask

  initial begin
    mismatch_cnt = 0;
    checked_cnt  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_ones = '0;
      emitted   = '0;
      sym_total = '0;
      symbol_q.delete();
      live_o    <= 1'b0;
      emitted_o <= '0;
      pending_o <= 0;
    end else begin
      if (total_we_i) sym_total = total_i;
      if (pop_i && !empty_i) check_symbol();
      if (push_i && !full_i) decode_byte(code_byte_i);
      live_o    <= (emitted < sym_total);
      emitted_o <= emitted;
      pending_o <= symbol_q.size();
    end
  end

endmodule

@@ tb/tb_clers_prefix_code_decoder.sv @@
`timescale 1ns / 100ps

module tb_clers_prefix_code_decoder;
  import cpd_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BYTES = 300;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  byte_t            code_byte = '0;
  logic             full;
  logic             total_we = 1'b0;
  total_t           total_data = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic [SYM_W-1:0] symbol;
  logic             last_of_byte;
  logic             finished;

  int     mismatches;
  int     symbols_checked;
  int     pending;
  logic   live;
  count_t emitted;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int live_bytes = 0;
  int phase_cnt = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  clers_prefix_code_decoder u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .code_byte_i       (code_byte),
    .full              (full),
    .symbol_total_we_i (total_we),
    .symbol_total_i    (total_data),
    .empty             (empty),
    .pop               (pop),
    .symbol_o          (symbol),
    .last_of_byte_o    (last_of_byte),
    .finished_o        (finished)
  );

  clers_prefix_code_decoder_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .code_byte_i       (code_byte),
    .total_we_i        (total_we),
    .total_i           (total_data),
    .empty_i           (empty),
    .pop_i             (pop),
    .symbol_i          (symbol),
    .last_of_byte_i    (last_of_byte),
    .finished_i        (finished),
    .mismatches_o      (mismatches),
    .symbols_checked_o (symbols_checked),
    .pending_o         (pending),
    .live_o            (live),
    .emitted_o         (emitted)
  );

  // symbol sink with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ends the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    code_byte <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    if (live) live_bytes++;
  endtask

  // hold off until every symbol is back and the bit engine has gone quiet
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_total(input total_t value);
    total_we   <= 1'b1;
    total_data <= value;
    @(posedge clk_i);
    total_we   <= 1'b0;
  endtask

  task automatic set_mode(input int mode);
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 70; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 70; end
      default: begin idle_pct = 9;  stall_pct = 9;  end
    endcase
  endtask

  function automatic byte_t rand_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  initial begin
    byte_t  directed[$];
    total_t next_total;
    int     random_start;
    int     burst;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero total: nothing may come out
    set_mode(0);
    write_total('0);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    // every code word, codes split across bytes, ends with three open ones
    write_total('1);
    directed = '{8'h00, 8'hFF, 8'hAA, 8'hDB, 8'h7F, 8'h0F, 8'hE0, 8'h01,
                 8'h80, 8'hFE, 8'h55, 8'hC3, 8'h07};
    foreach (directed[i]) send_byte(directed[i]);
    drain();

    // total lowered to the count mid-code: stops at once, open ones kept
    write_total(emitted);
    send_byte(8'h00);
    drain();

    // resume: first bit closes the open S, three C follow, then stop drops the rest
    write_total(total_t'(emitted + 4));
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    // total below the count
    write_total(total_t'(emitted - 1));
    send_byte(8'h00);
    drain();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      set_mode(phase_cnt % 4);
      burst = $urandom_range(15, 40);
      case ($urandom_range(7))
        0, 1: next_total = '1;
        2:    next_total = total_t'(emitted + $urandom_range(1, 3));
        3:    next_total = total_t'(emitted + $urandom_range(10, 60));
        4: begin
          next_total = emitted;
          burst = 3;
        end
        5: begin
          next_total = '0;
          burst = 3;
        end
        default: next_total = total_t'(emitted + $urandom_range(60, 200));
      endcase
      write_total(next_total);
      repeat (burst) send_byte(rand_byte());
      drain();
      phase_cnt++;
    end

    $display("covered %0d code bytes (%0d while decoding) in %0d random phases", bytes_sent,
             live_bytes, phase_cnt);
    $display("checked %0d symbols, totals from zero to full scale, four idle patterns",
             symbols_checked);
    if (pending != 0)
      $display("%0d symbols never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
